// ===== design/tm_pkg.sv =====
// Constants, types and cosine table builder for the transverse mass pipeline.
package tm_pkg;

	localparam int PT_BITS       = 16;
	localparam int ANGLE_BITS    = 12;
	localparam int COS_FRAC_BITS = 16;
	localparam int MASS_W        = 17;

	localparam int QUARTER = 2 ** (ANGLE_BITS - 2);
	localparam int IDX_W   = ANGLE_BITS - 1;
	localparam int COS_W   = COS_FRAC_BITS + 1;
	localparam int OMC_W   = COS_FRAC_BITS + 2;
	localparam int AB_W    = 2 * PT_BITS - 1;
	localparam int PROD_W  = AB_W + OMC_W;
	localparam int X_W     = 2 * PT_BITS + 1;
	localparam int ROOT_W  = PT_BITS + 1;
	localparam int SQ_W    = 2 * ROOT_W;
	localparam int REM_W   = ROOT_W + 1;

	localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

	localparam logic [63:0] TAYLOR_DIV [1:10] = '{
		64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
		64'd132, 64'd182, 64'd240, 64'd306, 64'd380
	};

	localparam logic [OMC_W-1:0]      COS_ONE      = OMC_W'(1) << COS_FRAC_BITS;
	localparam logic [ANGLE_BITS-1:0] HALF_TURN    = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
	localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

	typedef logic [COS_W-1:0] cos_tab_t [QUARTER+1];

	// Quarter-wave cosine in Q(COS_FRAC_BITS), Taylor series summed in Q30.
	function automatic logic [63:0] cos_quarter(input logic [63:0] k);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] sum;
		x    = (k * PI_HALF_Q30 + (64'd1 << (ANGLE_BITS - 3))) >> (ANGLE_BITS - 2);
		x2   = (x * x) >> 30;
		term = Q30_ONE;
		sum  = $signed(Q30_ONE);
		for (int n = 1; n <= 10; n++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[n];
			if (n[0]) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		if (sum < 0) begin
			sum = '0;
		end
		if (sum > $signed(Q30_ONE)) begin
			sum = $signed(Q30_ONE);
		end
		return ($unsigned(sum) + (64'd1 << (29 - COS_FRAC_BITS))) >> (30 - COS_FRAC_BITS);
	endfunction

	function automatic cos_tab_t build_cos_tab();
		cos_tab_t t;
		for (int k = 0; k <= QUARTER; k++) begin
			t[k] = COS_W'(cos_quarter(64'(k)));
		end
		return t;
	endfunction

endpackage

// ===== design/transverse_mass.sv =====
// Transverse mass pipeline: magnitude and angle fold, cosine ROM, product, digit sqrt.
// Registers from accepted pair to result word: stage 1, stage 2, stage 3, then the sqrt stages.
// Throughput: one word per cycle unless mass_ready stalls the output; the sqrt takes one result bit per stage.
// Valid bits ride with the data; a stalled stage holds and earlier bubbles collapse.
// Reset: arst_n clears every valid bit at once; payload registers are not reset.
module transverse_mass
	import tm_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pair_valid,
	output logic                         pair_ready,
	input  logic signed [PT_BITS-1:0]    pt_first,
	input  logic signed [PT_BITS-1:0]    pt_second,
	input  logic signed [ANGLE_BITS-1:0] phi_first,
	input  logic signed [ANGLE_BITS-1:0] phi_second,
	output logic                         mass_valid,
	input  logic                         mass_ready,
	output logic [MASS_W-1:0]            mass_out
);

	localparam cos_tab_t COS_TAB = build_cos_tab();

	logic                  vld_s1, vld_s2, vld_s3;
	logic                  en_s1, en_s2, en_s3;
	logic [PT_BITS-1:0]    mag_a_s1, mag_b_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic                  neg_s1, neg_s2;
	logic [COS_W-1:0]      cos_s2;
	logic [AB_W-1:0]       ab_s2;
	logic [SQ_W-1:0]       x_s3;

	logic [PT_BITS-1:0]    raw_a, raw_b, mag_a, mag_b;
	logic [ANGLE_BITS-1:0] diff, fold;
	logic [IDX_W-1:0]      idx;
	logic                  neg;
	logic [OMC_W-1:0]      omc;
	logic [PROD_W-1:0]     prod;

	logic [ROOT_W-1:0]     vld_sq, en_sq, vin_sq;
	logic [REM_W-1:0]      rem_sq_s  [ROOT_W];
	logic [ROOT_W-1:0]     root_sq_s [ROOT_W];
	logic [SQ_W-1:0]       rad_sq_s  [ROOT_W];
	logic [REM_W-1:0]      rem_in    [ROOT_W];
	logic [ROOT_W-1:0]     root_in   [ROOT_W];
	logic [SQ_W-1:0]       rad_in    [ROOT_W];
	logic [REM_W+1:0]      tmp_c     [ROOT_W];
	logic [REM_W+1:0]      trial_c   [ROOT_W];
	logic [REM_W-1:0]      rem_nx    [ROOT_W];
	logic [ROOT_W-1:0]     root_nx   [ROOT_W];

	// stage enables: advance when empty or when the next stage advances
	always_comb begin
		en_sq[ROOT_W-1] = ~vld_sq[ROOT_W-1] | mass_ready;
		for (int k = ROOT_W - 2; k >= 0; k--) begin
			en_sq[k] = ~vld_sq[k] | en_sq[k+1];
		end
		en_s3 = ~vld_s3 | en_sq[0];
		en_s2 = ~vld_s2 | en_s3;
		en_s1 = ~vld_s1 | en_s2;
	end

	assign pair_ready = en_s1;

	// stage 1: magnitudes and folded angle index
	always_comb begin
		raw_a = pt_first;
		raw_b = pt_second;
		mag_a = raw_a[PT_BITS-1] ? (~raw_a + 1'b1) : raw_a;
		mag_b = raw_b[PT_BITS-1] ? (~raw_b + 1'b1) : raw_b;
		diff  = phi_first - phi_second;
		fold  = (diff > HALF_TURN) ? (~diff + 1'b1) : diff;
		neg   = fold > QUARTER_TURN;
		idx   = neg ? IDX_W'(HALF_TURN - fold) : IDX_W'(fold);
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			mag_a_s1 <= mag_a;
			mag_b_s1 <= mag_b;
			idx_s1   <= idx;
			neg_s1   <= neg;
		end
	end

	// stage 2: cosine ROM read, momentum product
	always_ff @(posedge clk) begin
		if (en_s2) begin
			cos_s2 <= COS_TAB[idx_s1];
			ab_s2  <= AB_W'(mag_a_s1) * AB_W'(mag_b_s1);
			neg_s2 <= neg_s1;
		end
	end

	// stage 3: one minus cosine times product, drop fraction bits
	always_comb begin
		omc  = neg_s2 ? (COS_ONE + OMC_W'(cos_s2)) : (COS_ONE - OMC_W'(cos_s2));
		prod = PROD_W'(ab_s2) * PROD_W'(omc);
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			x_s3 <= SQ_W'(prod[COS_FRAC_BITS-1 +: X_W]);
		end
	end

	// sqrt stages: one root bit per stage, two radicand bits consumed
	always_comb begin
		rem_in[0]  = '0;
		root_in[0] = '0;
		rad_in[0]  = x_s3;
		vin_sq[0]  = vld_s3;
		for (int k = 1; k < ROOT_W; k++) begin
			rem_in[k]  = rem_sq_s[k-1];
			root_in[k] = root_sq_s[k-1];
			rad_in[k]  = rad_sq_s[k-1];
			vin_sq[k]  = vld_sq[k-1];
		end
		for (int k = 0; k < ROOT_W; k++) begin
			tmp_c[k]   = {rem_in[k], rad_in[k][SQ_W-1 -: 2]};
			trial_c[k] = (REM_W+2)'({root_in[k], 2'b01});
			if (tmp_c[k] >= trial_c[k]) begin
				rem_nx[k]  = REM_W'(tmp_c[k] - trial_c[k]);
				root_nx[k] = {root_in[k][ROOT_W-2:0], 1'b1};
			end else begin
				rem_nx[k]  = REM_W'(tmp_c[k]);
				root_nx[k] = {root_in[k][ROOT_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < ROOT_W; k++) begin
			if (en_sq[k]) begin
				rem_sq_s[k]  <= rem_nx[k];
				root_sq_s[k] <= root_nx[k];
				rad_sq_s[k]  <= {rad_in[k][SQ_W-3:0], 2'b00};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_sq <= '0;
		end else begin
			if (en_s1) begin
				vld_s1 <= pair_valid;
			end
			if (en_s2) begin
				vld_s2 <= vld_s1;
			end
			if (en_s3) begin
				vld_s3 <= vld_s2;
			end
			for (int k = 0; k < ROOT_W; k++) begin
				if (en_sq[k]) begin
					vld_sq[k] <= vin_sq[k];
				end
			end
		end
	end

	assign mass_valid = vld_sq[ROOT_W-1];
	assign mass_out   = MASS_W'(root_sq_s[ROOT_W-1]);

	a_stall_keeps_word: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !en_s1 |=> vld_s1)
		else $error("stage 1 word dropped during stall");

	a_cos_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> cos_s2 <= COS_W'(COS_ONE))
		else $error("cosine table value above one");

	a_sqrt_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		mass_valid |-> rem_sq_s[ROOT_W-1] <= {root_sq_s[ROOT_W-1], 1'b0})
		else $error("sqrt remainder exceeds twice the root");

	a_mass_bound: assert property (@(posedge clk) disable iff (!arst_n)
		mass_valid |-> root_sq_s[ROOT_W-1] <= (ROOT_W'(1) << (PT_BITS - 1 + 1)))
		else $error("mass above full scale");

endmodule
